// ----- rtl/htsd_pkg.sv -----
// Shared types and constants for the tree-walk stream decoder.
// Item structs, request, kind and status codes, internal command format.
// No dependencies.
package htsd_pkg;

    localparam int SYM_W  = 9;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 7;

    localparam logic [1:0] REQ_RESET  = 2'd0;
    localparam logic [1:0] REQ_LOAD   = 2'd1;
    localparam logic [1:0] REQ_DECODE = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [1:0] KIND_SYM    = 2'd0;
    localparam logic [1:0] KIND_EOS    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ON_NODE = 3'd1;
    localparam logic [2:0] ST_THROUGH = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_MISSING = 3'd4;

    localparam logic [SYM_W-1:0] EOS_SYMBOL   = 9'd256;
    localparam logic [LEN_W-1:0] MAX_CODE_LEN = 7'd32;
    localparam logic [LEN_W-1:0] CODE_BITS    = 7'd32;
    localparam logic [7:0]       DATA_MSB     = 8'h80;
    localparam logic [3:0]       BYTE_BITS    = 4'd8;

    typedef enum logic [1:0] {
        OP_RESET,
        OP_LOAD,
        OP_DECODE
    } t_op;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [SYM_W-1:0]  symbol_id;
        logic [CODE_W-1:0] code_bits;
        logic [5:0]        code_len;
        logic [7:0]        data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] symbol;
        logic [2:0] status;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_op               op;
        logic [SYM_W-1:0]  symbol_id;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
        logic [7:0]        data_byte;
    } t_cmd;

endpackage

// ----- rtl/htsd_fifo.sv -----
// Small synchronous queue with registered storage and occupancy count.
// Used for the command queue and the result queue. No dependencies.
module htsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/htsd_front.sv -----
// Front end: accepts input items, drops unknown requests, clips code length
// and queues commands for the back end. Depends on htsd_pkg and htsd_fifo.
module htsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  htsd_pkg::t_in_item  i_item,
    output logic                o_full,
    output htsd_pkg::t_cmd      o_cmd,
    output logic                o_cmd_empty,
    input  logic                i_cmd_pop
);

    htsd_pkg::t_cmd                   w_cmd;
    logic                             w_keep;
    logic [htsd_pkg::LEN_W-1:0]       w_len;
    logic [$bits(htsd_pkg::t_cmd)-1:0] w_head;

    always_comb begin
        w_len = {1'b0, i_item.code_len};
        if (w_len > htsd_pkg::MAX_CODE_LEN) begin
            w_len = htsd_pkg::MAX_CODE_LEN;
        end
        w_keep = 1'b1;
        case (i_item.req_type)
            htsd_pkg::REQ_RESET:  w_cmd.op = htsd_pkg::OP_RESET;
            htsd_pkg::REQ_LOAD:   w_cmd.op = htsd_pkg::OP_LOAD;
            htsd_pkg::REQ_DECODE: w_cmd.op = htsd_pkg::OP_DECODE;
            default: begin
                w_cmd.op = htsd_pkg::OP_DECODE;
                w_keep   = 1'b0;
            end
        endcase
        w_cmd.symbol_id = i_item.symbol_id;
        w_cmd.code_bits = i_item.code_bits;
        w_cmd.code_len  = w_len;
        w_cmd.data_byte = i_item.data_byte;
    end

    htsd_fifo #(
        .WIDTH ($bits(htsd_pkg::t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && w_keep),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (w_head),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = htsd_pkg::t_cmd'(w_head);

endmodule

// ----- rtl/htsd_back.sv -----
// Back end: node memory, table build and bit-by-bit tree walk.
// Takes commands from the front queue, pushes results. Depends on htsd_pkg.
module htsd_back #(
    parameter int NODE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  htsd_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_empty,
    output logic                o_cmd_pop,
    output logic                o_res_push,
    output htsd_pkg::t_out_item o_res,
    input  logic                i_res_full
);

    localparam int AW = $clog2(NODE_DEPTH);
    localparam int UW = AW + 1;
    localparam int SW = ((UW > htsd_pkg::LEN_W) ? UW : htsd_pkg::LEN_W) + 1;
    localparam int LW = htsd_pkg::LEN_W;

    typedef struct packed {
        logic [AW-1:0]             left;
        logic [AW-1:0]             right;
        logic                      leaf;
        logic [htsd_pkg::SYM_W-1:0] sym;
    } t_node;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REPORT,
        S_CHK,
        S_COMMIT,
        S_LEAFW,
        S_DEC,
        S_FLUSH
    } t_state;

    t_node                        r_mem [NODE_DEPTH];
    t_node                        r_rd;
    t_state                       r_state;
    logic [AW-1:0]                r_root_left;
    logic [AW-1:0]                r_root_right;
    logic [UW-1:0]                r_used;
    logic [AW-1:0]                r_walk;
    logic                         r_ended;
    logic                         r_fault;
    logic [2:0]                   r_fcode;
    logic [htsd_pkg::SYM_W-1:0]   r_sym;
    logic [htsd_pkg::CODE_W-1:0]  r_bits;
    logic [LW-1:0]                r_len;
    logic [7:0]                   r_byte;
    logic [LW-1:0]                r_depth;
    logic [AW-1:0]                r_n;
    t_node                        r_cur;
    logic [AW-1:0]                r_c;
    logic                         r_pend;
    logic [3:0]                   r_bit;
    logic [2:0]                   r_st;
    logic                         r_hold_v;
    htsd_pkg::t_out_item          r_hold;

    t_node                        w_root;
    t_node                        w_node;
    t_node                        w_par;
    logic [LW-1:0]                w_pos;
    logic                         w_code_bit;
    logic                         w_dir;
    logic [AW-1:0]                w_child;
    logic                         w_last_step;
    logic [SW-1:0]                w_need;
    logic                         w_over;
    logic                         w_leaf_hit;
    logic                         w_emit;
    logic [AW-1:0]                w_m;
    logic                         w_re;
    logic [AW-1:0]                w_ra;
    logic                         w_we;
    logic [AW-1:0]                w_wa;
    t_node                        w_wd;

    always_comb begin
        w_root = '{left: r_root_left, right: r_root_right, leaf: 1'b0, sym: '0};
        if (r_state == S_CHK) begin
            w_node = (r_n == '0) ? w_root : r_rd;
        end else begin
            w_node = (r_pend || r_walk != '0) ? r_rd : w_root;
        end
        w_pos       = r_len - LW'(1) - r_depth;
        w_code_bit  = (w_pos < htsd_pkg::CODE_BITS) ? r_bits[w_pos[4:0]] : 1'b0;
        w_dir       = (r_state == S_DEC) ? ((r_byte & htsd_pkg::DATA_MSB) != '0)
                                         : w_code_bit;
        w_child     = w_dir ? w_node.right : w_node.left;
        w_last_step = (r_depth == r_len - LW'(1));
        w_need      = SW'(r_used) + SW'(r_len - r_depth);
        w_over      = (w_need > SW'(NODE_DEPTH));
        w_leaf_hit  = r_pend && r_rd.leaf;
        w_emit      = w_leaf_hit || (r_bit != htsd_pkg::BYTE_BITS && w_child == '0);
        w_m         = r_used[AW-1:0];
        w_par       = r_cur;
        if (w_code_bit) begin
            w_par.right = w_m;
        end else begin
            w_par.left = w_m;
        end

        w_re = 1'b0;
        w_ra = w_child;
        w_we = 1'b0;
        w_wa = r_n;
        w_wd = r_cur;
        o_res_push = 1'b0;
        o_res      = r_hold;
        case (r_state)
            S_IDLE: begin
                w_re = 1'b1;
                w_ra = r_walk;
            end
            S_CHK: begin
                w_re = 1'b1;
            end
            S_COMMIT: begin
                w_we = (r_n != '0);
                w_wd = w_par;
            end
            S_LEAFW: begin
                w_we = 1'b1;
            end
            S_DEC: begin
                w_re       = !i_res_full && !w_leaf_hit;
                o_res_push = !i_res_full && r_hold_v && w_emit;
            end
            S_REPORT: begin
                o_res_push = !i_res_full;
                o_res = '{kind: htsd_pkg::KIND_STATUS, symbol: '0, status: r_st, last: 1'b1};
            end
            S_FLUSH: begin
                o_res_push  = !i_res_full && r_hold_v;
                o_res.last  = 1'b1;
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
        o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_root_left  <= '0;
            r_root_right <= '0;
            r_used       <= UW'(1);
            r_walk       <= '0;
            r_ended      <= 1'b0;
            r_fault      <= 1'b0;
            r_fcode      <= htsd_pkg::ST_OK;
            r_pend       <= 1'b0;
            r_hold_v     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_sym   <= i_cmd.symbol_id;
                        r_bits  <= i_cmd.code_bits;
                        r_len   <= i_cmd.code_len;
                        r_byte  <= i_cmd.data_byte;
                        r_depth <= '0;
                        r_n     <= '0;
                        r_bit   <= '0;
                        r_pend  <= 1'b0;
                        case (i_cmd.op)
                            htsd_pkg::OP_RESET: begin
                                r_root_left  <= '0;
                                r_root_right <= '0;
                                r_used       <= UW'(1);
                                r_walk       <= '0;
                                r_ended      <= 1'b0;
                                r_fault      <= 1'b0;
                                r_fcode      <= htsd_pkg::ST_OK;
                                r_st         <= htsd_pkg::ST_OK;
                                r_state      <= S_REPORT;
                            end
                            htsd_pkg::OP_LOAD: begin
                                if (r_fault) begin
                                    r_st    <= r_fcode;
                                    r_state <= S_REPORT;
                                end else if (i_cmd.code_len == '0) begin
                                    r_st    <= htsd_pkg::ST_OK;
                                    r_state <= S_REPORT;
                                end else begin
                                    r_state <= S_CHK;
                                end
                            end
                            htsd_pkg::OP_DECODE: begin
                                if (r_fault) begin
                                    r_st    <= r_fcode;
                                    r_state <= S_REPORT;
                                end else if (!r_ended) begin
                                    r_state <= S_DEC;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CHK: begin
                    if (r_n != '0 && r_rd.leaf) begin
                        r_fault <= 1'b1;
                        r_fcode <= htsd_pkg::ST_THROUGH;
                        r_st    <= htsd_pkg::ST_THROUGH;
                        r_state <= S_REPORT;
                    end else if (w_child == '0) begin
                        if (w_over) begin
                            r_fault <= 1'b1;
                            r_fcode <= htsd_pkg::ST_FULL;
                            r_st    <= htsd_pkg::ST_FULL;
                            r_state <= S_REPORT;
                        end else begin
                            r_cur   <= w_node;
                            r_state <= S_COMMIT;
                        end
                    end else if (w_last_step) begin
                        r_fault <= 1'b1;
                        r_fcode <= htsd_pkg::ST_ON_NODE;
                        r_st    <= htsd_pkg::ST_ON_NODE;
                        r_state <= S_REPORT;
                    end else begin
                        r_n     <= w_child;
                        r_depth <= r_depth + LW'(1);
                    end
                end
                S_COMMIT: begin
                    if (r_n == '0) begin
                        if (w_code_bit) begin
                            r_root_right <= w_m;
                        end else begin
                            r_root_left <= w_m;
                        end
                    end
                    r_cur   <= '{left: '0, right: '0, leaf: w_last_step,
                                 sym: w_last_step ? r_sym : '0};
                    r_n     <= w_m;
                    r_used  <= r_used + UW'(1);
                    r_depth <= r_depth + LW'(1);
                    if (w_last_step) begin
                        r_state <= S_LEAFW;
                    end
                end
                S_LEAFW: begin
                    r_st    <= htsd_pkg::ST_OK;
                    r_state <= S_REPORT;
                end
                S_DEC: begin
                    if (!i_res_full) begin
                        if (w_leaf_hit) begin
                            r_pend   <= 1'b0;
                            r_walk   <= '0;
                            r_hold_v <= 1'b1;
                            if (r_rd.sym == htsd_pkg::EOS_SYMBOL) begin
                                r_ended <= 1'b1;
                                r_hold  <= '{kind: htsd_pkg::KIND_EOS, symbol: '0,
                                             status: htsd_pkg::ST_OK, last: 1'b0};
                                r_state <= S_FLUSH;
                            end else begin
                                r_hold <= '{kind: htsd_pkg::KIND_SYM, symbol: r_rd.sym[7:0],
                                            status: htsd_pkg::ST_OK, last: 1'b0};
                                if (r_bit == htsd_pkg::BYTE_BITS) begin
                                    r_state <= S_FLUSH;
                                end
                            end
                        end else begin
                            if (r_pend) begin
                                r_walk <= r_c;
                                r_pend <= 1'b0;
                            end
                            if (r_bit == htsd_pkg::BYTE_BITS) begin
                                r_state <= S_FLUSH;
                            end else if (w_child == '0) begin
                                r_fault  <= 1'b1;
                                r_fcode  <= htsd_pkg::ST_MISSING;
                                r_hold_v <= 1'b1;
                                r_hold   <= '{kind: htsd_pkg::KIND_STATUS, symbol: '0,
                                              status: htsd_pkg::ST_MISSING, last: 1'b0};
                                r_state  <= S_FLUSH;
                            end else begin
                                r_c    <= w_child;
                                r_pend <= 1'b1;
                                r_bit  <= r_bit + 4'd1;
                                r_byte <= {r_byte[6:0], 1'b0};
                            end
                        end
                    end
                end
                S_REPORT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    if (!r_hold_v) begin
                        r_state <= S_IDLE;
                    end else if (!i_res_full) begin
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/huffman_tree_stream_decoder_core.sv -----
// Huffman tree-walk stream decoder, top level: front queue, back engine,
// result queue. One item in flight in the back engine at a time.
// Synchronous reset empties both queues and gives an empty tree at once.
module huffman_tree_stream_decoder_core #(
    parameter int NODE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  htsd_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output htsd_pkg::t_out_item o_result
);

    htsd_pkg::t_cmd                       w_cmd;
    logic                                 w_cmd_empty;
    logic                                 w_cmd_pop;
    logic                                 w_res_push;
    logic                                 w_res_full;
    htsd_pkg::t_out_item                  w_res;
    logic [$bits(htsd_pkg::t_out_item)-1:0] w_res_head;

    htsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd       (w_cmd),
        .o_cmd_empty (w_cmd_empty),
        .i_cmd_pop   (w_cmd_pop)
    );

    htsd_back #(
        .NODE_DEPTH (NODE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    htsd_fifo #(
        .WIDTH ($bits(htsd_pkg::t_out_item)),
        .DEPTH (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_head),
        .o_empty (empty)
    );

    assign o_result = htsd_pkg::t_out_item'(w_res_head);

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_res_full))
        else $error("result pushed into full queue");

    a_cmd_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd_pop && w_cmd_empty))
        else $error("command popped from empty queue");

    a_final_kinds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res.kind != htsd_pkg::KIND_SYM) |-> w_res.last)
        else $error("end-of-stream or status transfer without last");

    a_sym_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res.kind != htsd_pkg::KIND_STATUS) |->
            w_res.status == htsd_pkg::ST_OK)
        else $error("symbol transfer with non-zero status");

endmodule

// ----- test/tb_huffman_tree_stream_decoder_core.sv -----
// Testbench for the tree-walk stream decoder: directed and random request streams,
// checked against a behavioural copy of the decode tree.
// Depends on htsd_pkg and huffman_tree_stream_decoder_core.
module tb_huffman_tree_stream_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TREE_SLOTS    = 1024;
    localparam int RUN_ITEMS     = 320;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        htsd_pkg::t_in_item item;
        logic               drain;
    } t_send;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    htsd_pkg::t_in_item  i_item = '0;
    logic                empty;
    logic                pop = 1'b0;
    htsd_pkg::t_out_item o_result;

    logic [9:0] tree_left  [TREE_SLOTS];
    logic [9:0] tree_right [TREE_SLOTS];
    logic       tree_leaf  [TREE_SLOTS];
    logic [8:0] tree_sym   [TREE_SLOTS];
    int         tree_count;
    logic [9:0] walk_node;
    logic       eos_seen;
    logic       fault_on;
    logic [2:0] fault_code;

    htsd_pkg::t_out_item answers_owed[$];
    t_send               send_q[$];
    int                  planned;
    int                  failures = 0;
    int                  cycle_count = 0;
    int                  push_rest = 0;
    int                  pop_rest = 0;
    logic                push_quiet = 1'b0;
    logic                pop_quiet = 1'b0;

    logic [31:0] gen_code [64];
    int          gen_len  [64];
    int          gen_count;

    huffman_tree_stream_decoder_core #(.NODE_DEPTH(TREE_SLOTS)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    task automatic clear_tree();
        for (int i = 0; i < TREE_SLOTS; i++) begin
            tree_left[i]  = '0;
            tree_right[i] = '0;
            tree_leaf[i]  = 1'b0;
            tree_sym[i]   = '0;
        end
        tree_count = 1;
        walk_node  = '0;
        eos_seen   = 1'b0;
        fault_on   = 1'b0;
        fault_code = htsd_pkg::ST_OK;
    endtask

    function automatic logic [9:0] child_of(logic [9:0] n, logic b);
        return b ? tree_right[n] : tree_left[n];
    endfunction

    function automatic htsd_pkg::t_out_item make_answer(logic [1:0] kind, logic [7:0] sym,
                                                        logic [2:0] st);
        htsd_pkg::t_out_item a;
        a.kind   = kind;
        a.symbol = sym;
        a.status = st;
        a.last   = 1'b0;
        return a;
    endfunction

    function automatic logic [2:0] insert_code(logic [8:0] sym, logic [31:0] code,
                                               logic [5:0] len_in);
        int         len;
        int         depth;
        logic [9:0] n;
        logic [9:0] c;
        len = (len_in > 6'd32) ? 32 : int'(len_in);
        if (len == 0) return htsd_pkg::ST_OK;
        n = '0;
        depth = 0;
        c = child_of(n, code[len - 1]);
        while (c != '0) begin
            if (depth == len - 1) return htsd_pkg::ST_ON_NODE;
            if (tree_leaf[c]) return htsd_pkg::ST_THROUGH;
            n = c;
            depth++;
            c = child_of(n, code[len - 1 - depth]);
        end
        if (tree_count + len - depth > TREE_SLOTS) return htsd_pkg::ST_FULL;
        while (depth < len) begin
            tree_left[tree_count]  = '0;
            tree_right[tree_count] = '0;
            tree_leaf[tree_count]  = (depth == len - 1);
            tree_sym[tree_count]   = (depth == len - 1) ? sym : '0;
            if (code[len - 1 - depth]) tree_right[n] = 10'(tree_count);
            else tree_left[n] = 10'(tree_count);
            n = 10'(tree_count);
            tree_count++;
            depth++;
        end
        return htsd_pkg::ST_OK;
    endfunction

    task automatic apply_request(htsd_pkg::t_in_item it);
        htsd_pkg::t_out_item res [8];
        int                  k;
        int                  i;
        logic [9:0]          c;
        logic                halted;
        logic [2:0]          st;
        k = 0;
        halted = 1'b0;
        case (it.req_type)
            htsd_pkg::REQ_RESET: begin
                clear_tree();
                res[0] = make_answer(htsd_pkg::KIND_STATUS, 8'h00, htsd_pkg::ST_OK);
                k = 1;
            end
            htsd_pkg::REQ_NONE: ;
            default: begin
                if (fault_on) begin
                    res[0] = make_answer(htsd_pkg::KIND_STATUS, 8'h00, fault_code);
                    k = 1;
                end else if (it.req_type == htsd_pkg::REQ_LOAD) begin
                    st = insert_code(it.symbol_id, it.code_bits, it.code_len);
                    if (st != htsd_pkg::ST_OK) begin
                        fault_on = 1'b1;
                        fault_code = st;
                    end
                    res[0] = make_answer(htsd_pkg::KIND_STATUS, 8'h00, st);
                    k = 1;
                end else if (!eos_seen) begin
                    for (i = 7; i >= 0 && !halted; i--) begin
                        c = child_of(walk_node, it.data_byte[i]);
                        if (c == '0) begin
                            fault_on = 1'b1;
                            fault_code = htsd_pkg::ST_MISSING;
                            res[k] = make_answer(htsd_pkg::KIND_STATUS, 8'h00,
                                                 htsd_pkg::ST_MISSING);
                            k++;
                            halted = 1'b1;
                        end else if (tree_leaf[c] && tree_sym[c] == htsd_pkg::EOS_SYMBOL) begin
                            eos_seen = 1'b1;
                            walk_node = '0;
                            res[k] = make_answer(htsd_pkg::KIND_EOS, 8'h00, htsd_pkg::ST_OK);
                            k++;
                            halted = 1'b1;
                        end else if (tree_leaf[c]) begin
                            res[k] = make_answer(htsd_pkg::KIND_SYM, tree_sym[c][7:0],
                                                 htsd_pkg::ST_OK);
                            k++;
                            walk_node = '0;
                        end else begin
                            walk_node = c;
                        end
                    end
                end
            end
        endcase
        if (k > 0) res[k - 1].last = 1'b1;
        for (i = 0; i < k; i++) answers_owed.push_back(res[i]);
    endtask

    task automatic check_answer(htsd_pkg::t_out_item got);
        htsd_pkg::t_out_item want;
        if (answers_owed.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: kind %0d symbol %02h status %0d last %0b",
                         got.kind, got.symbol, got.status, got.last);
        end else begin
            want = answers_owed.pop_front();
            if (got.kind != want.kind || got.symbol != want.symbol ||
                got.status != want.status || got.last != want.last) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch (kind/symbol/status/last): want %0d/%02h/%0d/%0b got %0d/%02h/%0d/%0b",
                             want.kind, want.symbol, want.status, want.last,
                             got.kind, got.symbol, got.status, got.last);
            end
        end
    endtask

    function automatic int pick_pause(logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic htsd_pkg::t_in_item any_item(logic [1:0] req);
        htsd_pkg::t_in_item it;
        it.req_type  = req;
        it.symbol_id = 9'($urandom_range(0, 511));
        it.code_bits = $urandom;
        it.code_len  = 6'($urandom_range(0, 63));
        it.data_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic logic [8:0] plain_symbol();
        logic [8:0] s;
        s = 9'($urandom_range(0, 510));
        if (s >= htsd_pkg::EOS_SYMBOL) s++;
        return s;
    endfunction

    task automatic queue_item(htsd_pkg::t_in_item it, logic drain);
        t_send s;
        s.item  = it;
        s.drain = drain;
        send_q.push_back(s);
        if (it.req_type != htsd_pkg::REQ_NONE) planned++;
    endtask

    task automatic queue_load(logic [8:0] sym, logic [31:0] code, logic [5:0] len);
        htsd_pkg::t_in_item it;
        logic [31:0]        keep;
        it = any_item(htsd_pkg::REQ_LOAD);
        keep = (len >= 6'd32) ? '1 : 32'((64'd1 << len) - 64'd1);
        it.symbol_id = sym;
        it.code_len  = len;
        it.code_bits = (code & keep) | (it.code_bits & ~keep);
        queue_item(it, 1'b0);
    endtask

    task automatic queue_decode(logic [7:0] b);
        htsd_pkg::t_in_item it;
        it = any_item(htsd_pkg::REQ_DECODE);
        it.data_byte = b;
        queue_item(it, 1'b0);
    endtask

    task automatic grow_code_set(int leaves, int deepest);
        int pick;
        int tries;
        gen_code[0] = 32'd0;
        gen_len[0]  = 1;
        gen_code[1] = 32'd1;
        gen_len[1]  = 1;
        gen_count   = 2;
        tries = 0;
        while (gen_count < leaves && tries < 1000) begin
            tries++;
            pick = ($urandom_range(0, 2) == 0) ? gen_count - 1 : $urandom_range(0, gen_count - 1);
            if (gen_len[pick] < deepest) begin
                gen_code[gen_count] = (gen_code[pick] << 1) | 32'd1;
                gen_len[gen_count]  = gen_len[pick] + 1;
                gen_code[pick]      = gen_code[pick] << 1;
                gen_len[pick]++;
                gen_count++;
            end
        end
    endtask

    task automatic queue_broken(int i);
        case ($urandom_range(0, 2))
            0: queue_load(plain_symbol(), gen_code[i], 6'(gen_len[i]));
            1: if (gen_len[i] > 1)
                queue_load(plain_symbol(), gen_code[i] >> 1, 6'(gen_len[i] - 1));
            default: if (gen_len[i] < 31)
                queue_load(plain_symbol(), {gen_code[i][29:0], 2'($urandom_range(0, 3))},
                           6'(gen_len[i] + 2));
        endcase
    endtask

    task automatic code_sequence();
        int          deepest;
        int          eos_at;
        int          skip_at;
        int          i;
        int          j;
        logic [31:0] tc;
        int          tl;
        logic [8:0]  sym;
        queue_item(any_item(htsd_pkg::REQ_RESET), 1'b0);
        deepest = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(3, 9);
        grow_code_set($urandom_range(2, 20), deepest);
        for (i = gen_count - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tc = gen_code[i];
            tl = gen_len[i];
            gen_code[i] = gen_code[j];
            gen_len[i]  = gen_len[j];
            gen_code[j] = tc;
            gen_len[j]  = tl;
        end
        eos_at  = ($urandom_range(0, 9) < 6) ? $urandom_range(0, gen_count - 1) : -1;
        skip_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gen_count - 1) : -1;
        for (i = 0; i < gen_count; i++) begin
            if (i != skip_at) begin
                sym = (i == eos_at) ? htsd_pkg::EOS_SYMBOL : plain_symbol();
                if (gen_len[i] == 32 && $urandom_range(0, 1) == 1)
                    queue_load(sym, gen_code[i], 6'($urandom_range(32, 63)));
                else
                    queue_load(sym, gen_code[i], 6'(gen_len[i]));
            end
            if ($urandom_range(0, 39) == 0) queue_broken(i);
            if ($urandom_range(0, 29) == 0) queue_decode(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 29) == 0) queue_load(plain_symbol(), $urandom, 6'd0);
        end
        repeat ($urandom_range(2, 12)) begin
            if ($urandom_range(0, 19) == 0) queue_item(any_item(htsd_pkg::REQ_NONE), 1'b0);
            queue_decode(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic store_fill();
        queue_item(any_item(htsd_pkg::REQ_RESET), 1'b0);
        repeat (40) queue_load(plain_symbol(), $urandom, 6'($urandom_range(32, 63)));
        queue_decode(8'($urandom_range(0, 255)));
        queue_item(any_item(htsd_pkg::REQ_RESET), 1'b0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                apply_request(i_item);
                void'(send_q.pop_front());
                if ($urandom_range(0, 49) == 0) push_quiet = !push_quiet;
                push_rest = pick_pause(push_quiet);
            end
            if (push && full) begin
                // hold the offered item
            end else if (push_rest > 0) begin
                push_rest--;
                push <= 1'b0;
            end else if (send_q.size() > 0 &&
                         (!send_q[0].drain || answers_owed.size() == 0)) begin
                i_item <= send_q[0].item;
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_answer(o_result);
                if ($urandom_range(0, 49) == 0) pop_quiet = !pop_quiet;
                pop_rest = pick_pause(pop_quiet);
            end
            if (pop_rest > 0) begin
                pop_rest--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int   fill_at;
        logic filled;
        clear_tree();
        planned = 0;

        // tree with a symbol leaf, an odd symbol, end of stream and one long code
        queue_item(any_item(htsd_pkg::REQ_RESET), 1'b0);
        queue_load(9'h041, 32'h0, 6'd0);
        queue_load(9'h041, 32'b0, 6'd1);
        queue_load(9'h1FF, 32'b10, 6'd2);
        queue_load(htsd_pkg::EOS_SYMBOL, 32'b110, 6'd3);
        queue_load(9'h000, 32'b1110, 6'd4);
        queue_load(9'h155, 32'hF000_0000, 6'd63);
        queue_decode(8'h00);
        queue_decode(8'h9D);
        queue_decode(8'hE0);
        queue_decode(8'h00);
        queue_decode(8'h00);
        queue_decode(8'h00);
        queue_decode(8'hC0);
        queue_decode(8'h00);
        queue_item(any_item(htsd_pkg::REQ_NONE), 1'b0);
        // code ending on an existing node, then latched fault
        queue_item(any_item(htsd_pkg::REQ_RESET), 1'b0);
        queue_load(9'h005, 32'b01, 6'd2);
        queue_load(9'h005, 32'b01, 6'd2);
        queue_load(9'h006, 32'b11, 6'd2);
        queue_decode(8'h00);
        // code through a leaf
        queue_item(any_item(htsd_pkg::REQ_RESET), 1'b0);
        queue_load(9'h007, 32'b1, 6'd1);
        queue_load(9'h008, 32'b10, 6'd2);
        // missing branch
        queue_item(any_item(htsd_pkg::REQ_RESET), 1'b0);
        queue_load(9'h003, 32'b0, 6'd1);
        queue_decode(8'h00);
        queue_decode(8'h80);
        queue_decode(8'h00);

        queue_item(any_item(htsd_pkg::REQ_RESET), 1'b1);
        fill_at = $urandom_range(60, 200);
        filled = 1'b0;
        while (planned < RUN_ITEMS) begin
            if (!filled && planned >= fill_at) begin
                store_fill();
                filled = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    queue_item(any_item(2'($urandom_range(0, 3))), 1'b0);
            end else begin
                code_sequence();
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (send_q.size() != 0) @(posedge i_clk);
        while (answers_owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0 && answers_owed.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
